### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the primality tester.
// Depends on nothing; the using module supplies clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// check on every rising clock edge outside reset
`define FPT_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fermat_primality_test: assertion failed");
// check on every rising clock edge, reset included
`define FPT_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("fermat_primality_test: assertion failed");
`else
`define FPT_ASSERT(label, prop)
`define FPT_ASSERT_ALWAYS(label, prop)
`endif
`endif

### rtl/fpt_pkg.sv
// Package of the Fermat primality tester: widths, bus sizes and FSM states.
// Depends on nothing.
`default_nettype none
package fpt_pkg;

  localparam int NUM_WIDTH  = 32;
  localparam int CNT_W      = $clog2(NUM_WIDTH);
  // stream payload widths, rounded up to whole bytes
  localparam int IN_DATA_W  = ((2 * NUM_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((NUM_WIDTH + 1 + 7) / 8) * 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_EXP,
    ST_MUL,
    ST_EMIT
  } fpt_state_t;

endpackage
`default_nettype wire

### rtl/fermat_primality_test.sv
// Fermat primality tester: one witness per transfer, verdict at group end.
// Steps: a number of 0..4 goes straight to its fixed verdict; else base reduction, then
// shift-and-add modular multiplies: one square per bit of number-1 plus one multiply
// per set bit of number-1.
// Throughput: one witness at a time, set by the single shift-and-add modular multiplier.
// Reset: synchronous active-low rst_n clears the FSM, output valid and sets the pass flag.
// Depends on fpt_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module fermat_primality_test import fpt_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // number, witness
  input  wire logic                  in_tlast,   // last_witness
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // tested_number, probably_prime, zero pad
  output logic                       out_tlast
);

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_WIDTH - 1);

  // s mod m for s < 2m
  function automatic logic [NUM_WIDTH-1:0] sub_if_ge(input logic [NUM_WIDTH:0] s,
                                                     input logic [NUM_WIDTH-1:0] m);
    logic [NUM_WIDTH+1:0] d;
    d = {1'b0, s} - {2'b00, m};
    return d[NUM_WIDTH+1] ? s[NUM_WIDTH-1:0] : d[NUM_WIDTH-1:0];
  endfunction

  // (x + y) mod m for x, y < m
  function automatic logic [NUM_WIDTH-1:0] add_mod(input logic [NUM_WIDTH-1:0] x,
                                                   input logic [NUM_WIDTH-1:0] y,
                                                   input logic [NUM_WIDTH-1:0] m);
    logic [NUM_WIDTH:0] s;
    s = {1'b0, x} + {1'b0, y};
    return sub_if_ge(s, m);
  endfunction

  fpt_state_t           state_r, state_nxt;
  logic [NUM_WIDTH-1:0] m_r, m_nxt;         // modulus, the number under test
  logic [NUM_WIDTH-1:0] e_r, e_nxt;         // exponent shift register, LSB first
  logic [NUM_WIDTH-1:0] base_r, base_nxt;   // running base, also remainder during reduce
  logic [NUM_WIDTH-1:0] acc_r, acc_nxt;     // power accumulator
  logic [NUM_WIDTH-1:0] mx_r, mx_nxt;       // multiplicand, doubled each step
  logic [NUM_WIDTH-1:0] my_r, my_nxt;       // multiplier bits shifted out one per cycle
  logic [NUM_WIDTH-1:0] mp_r, mp_nxt;       // partial product
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 sq_r, sq_nxt;       // current multiply is the squaring
  logic                 last_r, last_nxt;
  logic                 pass_r, pass_nxt;   // all witnesses of the group passed
  logic                 verdict_r, verdict_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [NUM_WIDTH-1:0] out_num_r, out_num_nxt;
  logic                 out_pp_r, out_pp_nxt;

  logic [NUM_WIDTH-1:0] in_num, in_wit;
  logic [NUM_WIDTH-1:0] sum_mp, dbl_mx, red_bit, mp_new;
  logic                 pass_now;

  assign in_num = in_tdata[NUM_WIDTH-1:0];
  assign in_wit = in_tdata[2*NUM_WIDTH-1:NUM_WIDTH];

  // datapath: one add and compare per register
  assign sum_mp  = add_mod(mp_r, mx_r, m_r);
  assign dbl_mx  = add_mod(mx_r, mx_r, m_r);
  assign red_bit = sub_if_ge({base_r, my_r[NUM_WIDTH-1]}, m_r);
  assign mp_new  = my_r[0] ? sum_mp : mp_r;
  assign pass_now = pass_r & (acc_r == NUM_WIDTH'(1));

  // ports
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({out_pp_r, out_num_r});
  assign out_tlast  = 1'b1;

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pass_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    m_r       <= m_nxt;
    e_r       <= e_nxt;
    base_r    <= base_nxt;
    acc_r     <= acc_nxt;
    mx_r      <= mx_nxt;
    my_r      <= my_nxt;
    mp_r      <= mp_nxt;
    cnt_r     <= cnt_nxt;
    sq_r      <= sq_nxt;
    last_r    <= last_nxt;
    verdict_r <= verdict_nxt;
    out_num_r <= out_num_nxt;
    out_pp_r  <= out_pp_nxt;
  end

  // sequencer: tiny n: emit; else reduce base, square-and-multiply over exponent bits
  always_comb begin
    state_nxt     = state_r;
    m_nxt         = m_r;
    e_nxt         = e_r;
    base_nxt      = base_r;
    acc_nxt       = acc_r;
    mx_nxt        = mx_r;
    my_nxt        = my_r;
    mp_nxt        = mp_r;
    cnt_nxt       = cnt_r;
    sq_nxt        = sq_r;
    last_nxt      = last_r;
    pass_nxt      = pass_r;
    verdict_nxt   = verdict_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_num_nxt   = out_num_r;
    out_pp_nxt    = out_pp_r;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          m_nxt    = in_num;
          last_nxt = in_tlast;
          if (in_num <= NUM_WIDTH'(4)) begin
            // tiny numbers: fixed verdict, no test
            verdict_nxt = (in_num == NUM_WIDTH'(2)) || (in_num == NUM_WIDTH'(3));
            state_nxt   = ST_EMIT;
          end else begin
            e_nxt     = in_num - NUM_WIDTH'(1);
            base_nxt  = '0;
            my_nxt    = in_wit;
            cnt_nxt   = '0;
            state_nxt = ST_REDUCE;
          end
        end
      end

      ST_REDUCE: begin
        // restoring remainder, witness bits MSB first
        base_nxt = red_bit;
        my_nxt   = {my_r[NUM_WIDTH-2:0], 1'b0};
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          acc_nxt   = NUM_WIDTH'(1);
          state_nxt = ST_EXP;
        end
      end

      ST_EXP: begin
        mp_nxt  = '0;
        cnt_nxt = '0;
        if (e_r == '0) begin
          pass_nxt    = pass_now;
          verdict_nxt = pass_now;
          state_nxt   = ST_EMIT;
        end else if (e_r[0]) begin
          mx_nxt    = acc_r;
          my_nxt    = base_r;
          sq_nxt    = 1'b0;
          state_nxt = ST_MUL;
        end else begin
          mx_nxt    = base_r;
          my_nxt    = base_r;
          sq_nxt    = 1'b1;
          state_nxt = ST_MUL;
        end
      end

      ST_MUL: begin
        // shift-and-add modular multiply, multiplier LSB first
        mp_nxt  = mp_new;
        mx_nxt  = dbl_mx;
        my_nxt  = {1'b0, my_r[NUM_WIDTH-1:1]};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          if (!sq_r) begin
            acc_nxt = mp_new;
            mx_nxt  = base_r;
            my_nxt  = base_r;
            mp_nxt  = '0;
            cnt_nxt = '0;
            sq_nxt  = 1'b1;
          end else begin
            base_nxt  = mp_new;
            e_nxt     = {1'b0, e_r[NUM_WIDTH-1:1]};
            state_nxt = ST_EXP;
          end
        end
      end

      ST_EMIT: begin
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_num_nxt   = m_r;
          out_pp_nxt    = verdict_r;
          pass_nxt      = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // operands of the multiplier must stay below the modulus
  `FPT_ASSERT(a_base_lt_mod, (state_r == ST_EXP) |-> (base_r < m_r))
  `FPT_ASSERT(a_acc_lt_mod, (state_r == ST_EXP) |-> (acc_r < m_r))
  // the squaring always hands back to the exponent step
  `FPT_ASSERT(a_square_ends, (state_r == ST_MUL && sq_r && cnt_r == CNT_LAST) |=> (state_r == ST_EXP))
  // a result is loaded only from the emit state
  `FPT_ASSERT(a_load_from_emit, (!out_valid_r && out_valid_nxt) |-> (state_r == ST_EMIT))

endmodule
`default_nettype wire

### test/fpt_verdict_checker.sv
// Verdict checker for the Fermat primality tester: watches the witness and verdict
// streams, predicts each group's verdict and compares it with what the block emits.
// Depends on fpt_pkg for the number width and stream payload widths.
`timescale 1ns / 100ps
module fpt_verdict_checker import fpt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // number, witness
  input  logic                  in_tlast,   // last_witness
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,  // tested_number, probably_prime, zero pad
  output int                    error_count,
  output int                    verdicts_owed,
  output int                    verdicts_checked,
  output int                    primes_seen
);

  typedef logic [NUM_WIDTH-1:0]   num_t;
  typedef logic [2*NUM_WIDTH-1:0] wide_t;
  typedef struct packed {
    num_t number;
    logic prime;
  } verdict_t;

  verdict_t verdict_q[$];
  logic     group_passed = 1'b1;

  // base^expo mod modulus by square-and-multiply; products fit the double width
  function automatic num_t mod_power(input num_t base, input num_t expo, input num_t modulus);
    wide_t acc;
    wide_t sq;
    num_t  e;
    acc = 1;
    sq  = wide_t'(base) % wide_t'(modulus);
    e   = expo;
    while (e != 0) begin
      if (e[0])
        acc = (acc * sq) % wide_t'(modulus);
      sq = (sq * sq) % wide_t'(modulus);
      e  = e >> 1;
    end
    return acc[NUM_WIDTH-1:0];
  endfunction

  always @(posedge clk) begin : watch
    num_t     n;
    num_t     w;
    num_t     got_number;
    logic     got_prime;
    logic     verdict;
    verdict_t want;
    if (!rst_n) begin
      verdict_q.delete();
      group_passed = 1'b1;
    end else begin
      // verdict transfer: compare with the oldest prediction
      if (out_tvalid && out_tready) begin
        got_number = out_tdata[NUM_WIDTH-1:0];
        got_prime  = out_tdata[NUM_WIDTH];
        if (verdict_q.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("%0t: unexpected verdict: number %0d prime %0b", $time,
                     got_number, got_prime);
        end else begin
          want = verdict_q.pop_front();
          verdicts_checked++;
          if (want.prime)
            primes_seen++;
          if (got_number !== want.number || got_prime !== want.prime) begin
            error_count++;
            if (error_count <= 10)
              $display("%0t: verdict mismatch: expected %0d prime %0b, got %0d prime %0b",
                       $time, want.number, want.prime, got_number, got_prime);
          end
        end
      end
      // witness transfer: update the group flag, predict on the last witness
      if (in_tvalid && in_tready) begin
        n = in_tdata[NUM_WIDTH-1:0];
        w = in_tdata[2*NUM_WIDTH-1:NUM_WIDTH];
        if (n <= 1 || n == 4) begin
          verdict = 1'b0;
        end else if (n <= 3) begin
          verdict = 1'b1;
        end else begin
          if (mod_power(w, n - 1, n) != 1)
            group_passed = 1'b0;
          verdict = group_passed;
        end
        if (in_tlast) begin
          want.number = n;
          want.prime  = verdict;
          verdict_q = {verdict_q, want};
          group_passed = 1'b1;
        end
      end
    end
    verdicts_owed = verdict_q.size();
  end

endmodule

### test/tb_top.sv
// Top of the primality tester bench: clock, reset, witness stimulus, verdict-side stalls.
// Depends on fpt_pkg, fermat_primality_test and fpt_verdict_checker.
`timescale 1ns / 100ps
module tb_top;
  import fpt_pkg::*;

  localparam int WITNESS_ITEMS = 256;
  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int DRAIN_CYCLES  = 2200;

  typedef logic [NUM_WIDTH-1:0] num_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // number, witness
  logic                  in_tlast;   // last_witness
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // tested_number, probably_prime, zero pad
  logic                  out_tlast;

  int error_count;
  int verdicts_owed;
  int verdicts_checked;
  int primes_seen;
  int witnesses_sent;
  int groups_sent;
  int cycle_count;
  int ready_hold;
  bit steady_flow;   // no idling on either side while set

  fermat_primality_test i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  fpt_verdict_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .in_tlast         (in_tlast),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .error_count      (error_count),
    .verdicts_owed    (verdicts_owed),
    .verdicts_checked (verdicts_checked),
    .primes_seen      (primes_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding", cycle_count,
               verdicts_owed);
      $display("[fermat_primality_test] ERROR");
      $finish;
    end
  end

  // verdict side: mostly ready, short stalls, the odd long one
  always @(negedge clk) begin
    int r;
    if (steady_flow) begin
      out_tready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold--;
      out_tready <= 1'b0;
    end else begin
      r = $urandom_range(99);
      if (r < 60) begin
        out_tready <= 1'b1;
      end else if (r < 92) begin
        ready_hold = $urandom_range(3, 1) - 1;
        out_tready <= 1'b0;
      end else begin
        ready_hold = $urandom_range(80, 20) - 1;
        out_tready <= 1'b0;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (steady_flow)
      return 0;
    r = $urandom_range(99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(3, 1);
    return $urandom_range(50, 10);
  endfunction

  function automatic num_t known_prime(input int idx);
    case (idx)
      0:       return 97;
      1:       return 251;
      2:       return 7919;
      3:       return 65521;
      4:       return 65537;
      5:       return 104729;
      6:       return 998244353;
      7:       return 1000000007;
      8:       return 32'h7FFF_FFFF;
      default: return 32'hFFFF_FFFB;
    endcase
  endfunction

  // composites that pass for every coprime base
  function automatic num_t pseudoprime(input int idx);
    case (idx)
      0:       return 561;
      1:       return 1105;
      2:       return 1729;
      3:       return 2465;
      4:       return 2821;
      5:       return 6601;
      default: return 8911;
    endcase
  endfunction

  function automatic num_t pick_number();
    int r;
    r = $urandom_range(99);
    if (r < 30)
      return $urandom;
    if (r < 60)
      return known_prime($urandom_range(9));
    if (r < 70)
      return pseudoprime($urandom_range(6));
    if (r < 80)
      return $urandom_range(20);
    if (r < 92)
      return $urandom_range(65535);
    return known_prime($urandom_range(9)) * known_prime($urandom_range(9));
  endfunction

  function automatic num_t pick_witness(input num_t n);
    int r;
    if (n < 4)
      return $urandom;
    r = $urandom_range(99);
    if (r < 70)
      return $urandom_range(n - 2, 2);
    if (r < 80)
      return $urandom;
    if (r < 85)
      return 0;
    if (r < 90)
      return 1;
    if (r < 95)
      return n - 1;
    return n * num_t'($urandom_range(3, 1));
  endfunction

  // one witness transfer; entered and left at a falling edge
  task automatic send_witness(input num_t n, input num_t w, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {w, n};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    witnesses_sent++;
    if (last)
      groups_sent++;
    @(negedge clk);
  endtask

  // hold the witness stream until every verdict is back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (verdicts_owed != 0)
      @(negedge clk);
  endtask

  initial begin
    int   random_sent;
    int   group_len;
    bit   paused;
    num_t n;
    num_t wn;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    out_tready  = 1'b0;
    steady_flow = 1'b0;
    ready_hold  = 0;
    random_sent = 0;
    paused      = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: small numbers, field extremes, degenerate witnesses
    send_witness(0, 0, 1'b1);
    send_witness(1, 32'hFFFF_FFFF, 1'b1);
    send_witness(2, 0, 1'b1);
    send_witness(3, 32'hFFFF_FFFF, 1'b1);
    send_witness(4, 3, 1'b1);
    send_witness(5, 10, 1'b1);                  // witness multiple of number
    send_witness(7, 1, 1'b1);
    send_witness(7, 6, 1'b1);                   // witness number-1
    send_witness(11, 11, 1'b1);                 // witness equal to number
    send_witness(32'hFFFF_FFFB, 32'hFFFF_FFFF, 1'b1);
    send_witness(32'hFFFF_FFFF, 2, 1'b1);
    send_witness(32'h7FFF_FFFF, 3, 1'b0);
    send_witness(32'h7FFF_FFFF, 32'h7FFF_FFFD, 1'b1);
    send_witness(561, 2, 1'b0);                 // pseudoprime: coprime base passes
    send_witness(561, 3, 1'b1);                 // shared factor fails the group
    // number changes inside a group
    send_witness(9, 2, 1'b0);
    send_witness(2, 5, 1'b1);                   // small number ignores the flag
    send_witness(15, 2, 1'b0);
    send_witness(4, 0, 1'b1);                   // small number still ends the group and sets the flag
    send_witness(13, 2, 1'b1);
    send_witness(4, 1, 1'b0);                   // small number leaves the flag alone
    send_witness(13, 2, 1'b1);
    send_witness(1105, 2, 1'b1);
    send_witness(32'hAAAA_AAAB, 32'h5555_5555, 1'b1);
    wait_drained();

    // random groups of one to four witnesses, mostly on one number
    while (random_sent < WITNESS_ITEMS) begin
      steady_flow = (random_sent >= 120 && random_sent < 170);
      if (!paused && random_sent >= 200) begin
        wait_drained();
        paused = 1'b1;
      end
      n         = pick_number();
      group_len = ($urandom_range(99) < 50) ? 1 : $urandom_range(4, 2);
      for (int k = 0; k < group_len; k++) begin
        wn = ($urandom_range(99) < 5) ? num_t'($urandom) : n;
        send_witness(wn, pick_witness(wn), k == group_len - 1);
        random_sent++;
      end
    end
    steady_flow = 1'b0;
    in_tvalid <= 1'b0;

    // drain, then give a stray verdict time to show up
    while (verdicts_owed != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("%0d witnesses in %0d groups sent, %0d verdicts checked, %0d of them prime",
             witnesses_sent, groups_sent, verdicts_checked, primes_seen);
    $display("small numbers, pseudoprimes, degenerate witnesses and mixed groups covered");
    if (error_count == 0 && verdicts_owed == 0) begin
      $display("[fermat_primality_test] OK");
    end else begin
      $display("%0d mismatches, %0d verdicts missing", error_count, verdicts_owed);
      $display("[fermat_primality_test] ERROR");
    end
    $finish;
  end

endmodule
